// ----- design/sibaa_pkg.sv -----
`timescale 1ns / 1ps

package sibaa_pkg;

    // fixed port and register widths
    localparam int VALUE_W      = 6;
    localparam int POS_W        = 3;
    localparam int SEED_TERMS_W = 48;
    localparam int SEED_W       = 6;

    // reload request from the sequencer to the term store
    typedef struct packed {
        logic clear;      // drop every written term
        logic from_seed;  // unwritten terms read from seeds, else as one
    } sibaa_load_t;

endpackage

// ----- design/scaled_ibaa_generator_unit.sv -----
`timescale 1ns / 1ps
// A taken request word starts a batch; each step runs FETCH, MIX, STORE and EMIT in turn
//   over the shared term memory; EMIT loads the result word into the output register and
//   waits while m_tready stalls. A batch of 2**LOG_TERMS words ends before IDLE takes the next.
// Reset: seeds return to their reset values, accumulator and previous result to one, every
//   memory term reads as one until written. No clearing pass.
module scaled_ibaa_generator_unit
    import sibaa_pkg::*;
#(
    parameter int LOG_TERMS = 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // [5:0] value, [8:6] position, [15:9] zero
    output logic                    m_tlast,   // last_of_batch
    // configuration writes
    input  logic                    cfg_wen,
    input  logic [1:0]              cfg_index,
    input  logic [SEED_TERMS_W-1:0] cfg_wdata
);

    localparam int TERMS = 1 << LOG_TERMS;
    localparam int VB    = 2 * LOG_TERMS;
    localparam logic [LOG_TERMS-1:0] HALF = LOG_TERMS'(TERMS / 2);
    localparam logic [LOG_TERMS-1:0] LAST = LOG_TERMS'(TERMS - 1);

    // register indexes
    localparam logic [1:0] CFG_SEED_TERMS = 2'd0;
    localparam logic [1:0] CFG_SEED_ACC   = 2'd1;
    localparam logic [1:0] CFG_SEED_PREV  = 2'd2;

    localparam logic [SEED_TERMS_W-1:0] SEED_TERMS_RST = 48'd71794002497;

    // barrel mix: (a << 4) ^ (a >> 2), kept to term width
    function automatic logic [VB-1:0] rot_mix(input logic [VB-1:0] a);
        rot_mix = VB'({a, 4'b0000}) ^ (a >> 2);
    endfunction

    // per step: FETCH reads m[i] and m[i+T/2], MIX forms a and reads m[x],
    // STORE forms y, writes m[i] and reads m[y>>L], EMIT forms b into the output register
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MIX,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [LOG_TERMS-1:0]    step_reg, step_next;
    logic [VB-1:0]           acc_reg, acc_next;
    logic [VB-1:0]           prev_reg, prev_next;
    logic [VB-1:0]           x_reg, x_next;
    logic [VB-1:0]           y_reg, y_next;
    logic                    fwd_reg, fwd_next;
    logic [SEED_TERMS_W-1:0] seed_terms_reg;
    logic [SEED_W-1:0]       seed_acc_reg;
    logic [SEED_W-1:0]       seed_prev_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic                    out_last_reg, out_last_next;

    logic                    in_fire;
    logic                    emit_fire;
    sibaa_load_t             load;
    logic [LOG_TERMS-1:0]    rd_addr0, rd_addr1;
    logic [VB-1:0]           rd_data0, rd_data1;
    logic                    wr_en;
    logic [VB-1:0]           y_sum;
    logic [VB-1:0]           b_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign load.clear     = in_fire && s_tdata[0];
    assign load.from_seed = 1'b1;

    assign y_sum = rd_data0 + acc_reg + prev_reg;
    // the term written in STORE may be the one read there: take it from y_reg
    assign b_sum = (fwd_reg ? y_reg : rd_data0) + x_reg;
    assign wr_en = (state_reg == ST_STORE);

    always_comb
    begin
        rd_addr0 = step_reg;
        rd_addr1 = step_reg + HALF;
        unique case (state_reg)
            ST_IDLE:  rd_addr0 = step_reg;
            ST_FETCH: rd_addr0 = step_reg;
            ST_MIX:   rd_addr0 = rd_data0[LOG_TERMS-1:0];
            ST_STORE: rd_addr0 = y_sum[VB-1:LOG_TERMS];
            ST_EMIT:  rd_addr0 = y_reg[VB-1:LOG_TERMS];
            default:  rd_addr0 = step_reg;
        endcase
    end

    sibaa_term_store #(
        .LOG_TERMS (LOG_TERMS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .seed_terms (seed_terms_reg),
        .rd_addr0   (rd_addr0),
        .rd_addr1   (rd_addr1),
        .rd_data0   (rd_data0),
        .rd_data1   (rd_data1),
        .wr_en      (wr_en),
        .wr_addr    (step_reg),
        .wr_data    (y_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        fwd_next       = fwd_reg;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    step_next  = '0;
                    state_next = ST_FETCH;
                    if (s_tdata[0])
                    begin
                        acc_next  = seed_acc_reg[VB-1:0];
                        prev_next = seed_prev_reg[VB-1:0];
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                x_next     = rd_data0;
                acc_next   = rot_mix(acc_reg) + rd_data1;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                y_next     = y_sum;
                fwd_next   = (y_sum[VB-1:LOG_TERMS] == step_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    prev_next      = b_sum;
                    out_value_next = VALUE_W'(b_sum);
                    out_pos_next   = POS_W'(step_reg);
                    out_last_next  = (step_reg == LAST);
                    out_valid_next = 1'b1;
                    step_next      = step_reg + 1'b1;
                    state_next     = (step_reg == LAST) ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            acc_reg        <= VB'(1);
            prev_reg       <= VB'(1);
            fwd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            seed_terms_reg <= SEED_TERMS_RST;
            seed_acc_reg   <= SEED_W'(1);
            seed_prev_reg  <= SEED_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            prev_reg      <= prev_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_SEED_TERMS: seed_terms_reg <= cfg_wdata;
                    CFG_SEED_ACC:   seed_acc_reg   <= cfg_wdata[SEED_W-1:0];
                    CFG_SEED_PREV:  seed_prev_reg  <= cfg_wdata[SEED_W-1:0];
                    default:        ;   // unused index, write dropped
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_pos_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("request taken while batch still running");

    a_step_starts_zero : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (step_reg == '0))
        else $error("batch did not start at step zero");

    a_last_matches_pos : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (out_pos_reg == POS_W'(TERMS - 1))))
        else $error("tlast disagrees with position");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result word changed while stalled");

    a_write_in_store : assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && out_valid_reg |-> m_tready)
        else $error("result overwritten before it was taken");
`endif

endmodule

// ----- design/sibaa_term_store.sv -----
`timescale 1ns / 1ps

// Term memory: one write port, two registered read ports.
// Unwritten entries read as one after reset, or as their seed term after a reload.
module sibaa_term_store
    import sibaa_pkg::*;
#(
    parameter int LOG_TERMS = 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sibaa_load_t             load,
    input  logic [SEED_TERMS_W-1:0] seed_terms,
    input  logic [LOG_TERMS-1:0]    rd_addr0,
    input  logic [LOG_TERMS-1:0]    rd_addr1,
    output logic [2*LOG_TERMS-1:0]  rd_data0,
    output logic [2*LOG_TERMS-1:0]  rd_data1,
    input  logic                    wr_en,
    input  logic [LOG_TERMS-1:0]    wr_addr,
    input  logic [2*LOG_TERMS-1:0]  wr_data
);

    localparam int TERMS = 1 << LOG_TERMS;
    localparam int VB    = 2 * LOG_TERMS;

    logic [VB-1:0]        mem [TERMS];
    logic [TERMS-1:0]     valid_reg;
    logic                 from_seed_reg;
    logic [VB-1:0]        q0_reg;
    logic [VB-1:0]        q1_reg;
    logic                 v0_reg;
    logic                 v1_reg;
    logic [LOG_TERMS-1:0] a0_reg;
    logic [LOG_TERMS-1:0] a1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q0_reg <= mem[rd_addr0];
        q1_reg <= mem[rd_addr1];
        a0_reg <= rd_addr0;
        a1_reg <= rd_addr1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            from_seed_reg <= 1'b0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
        end
        else
        begin
            if (load.clear)
            begin
                valid_reg     <= '0;
                from_seed_reg <= load.from_seed;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            v0_reg <= valid_reg[rd_addr0];
            v1_reg <= valid_reg[rd_addr1];
        end
    end

    always_comb
    begin
        if (v0_reg)
            rd_data0 = q0_reg;
        else if (from_seed_reg)
            rd_data0 = seed_terms[int'(a0_reg) * VB +: VB];
        else
            rd_data0 = VB'(1);

        if (v1_reg)
            rd_data1 = q1_reg;
        else if (from_seed_reg)
            rd_data1 = seed_terms[int'(a1_reg) * VB +: VB];
        else
            rd_data1 = VB'(1);
    end

endmodule
